// ----- design/urm_pkg.sv -----
`default_nettype none

package urm_pkg;

   // Sizing of the sorted row of cells
   localparam int MAX_PINGS = 16;
   localparam int CNT_W     = $clog2(MAX_PINGS + 1);
   localparam int IDX_W     = (MAX_PINGS > 1) ? $clog2(MAX_PINGS) : 1;

   // Field widths
   localparam int DIST_W  = 13;
   localparam int TICK_W  = 20;
   localparam int US_W    = 16;
   localparam int TRIG_W  = 8;
   localparam int REQ_W   = 5;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 20;

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_SCALE      = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_MAX_PULSE  = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_MIN_DIST   = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_MAX_DIST   = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_TIMEOUT    = 3'd4;
   localparam logic [CSR_A_W-1:0] CSR_PERIOD     = 3'd5;
   localparam logic [CSR_A_W-1:0] CSR_TRIG_WIDTH = 3'd6;

   // Register reset values
   localparam logic [US_W-1:0]   RST_SCALE      = 16'd1126;
   localparam logic [US_W-1:0]   RST_MAX_PULSE  = 16'd29099;
   localparam logic [DIST_W-1:0] RST_MIN_DIST   = 13'd48;
   localparam logic [DIST_W-1:0] RST_MAX_DIST   = 13'd8000;
   localparam logic [US_W-1:0]   RST_TIMEOUT    = 16'd29000;
   localparam logic [TICK_W-1:0] RST_PERIOD     = 20'd40000;
   localparam logic [TRIG_W-1:0] RST_TRIG_WIDTH = 8'd10;

   typedef struct packed {
      logic             start_req;
      logic [REQ_W-1:0] pings_requested;
      logic             echo_level;
   } urm_req_type;

   typedef struct packed {
      logic              trigger_level;
      logic              busy_res;
      logic              ping_done;
      logic              ping_echoed;
      logic [DIST_W-1:0] ping_cm_q4;
      logic              median_done;
      logic              median_found;
      logic [DIST_W-1:0] median_cm_q4;
      logic [REQ_W-1:0]  pings_used;
   } urm_rsp_type;

   // Control broadcast along the row of cells
   typedef struct packed {
      logic              clear;
      logic              ins;
      logic [DIST_W-1:0] value;
   } urm_sort_ctl_type;

   // Zero counts as one ping, large counts are held at the row length
   function automatic logic [CNT_W-1:0] clamp_pings(input logic [REQ_W-1:0] req);
      int v;
      v = int'(req);
      if (v == 0) begin
         v = 1;
      end
      if (v > MAX_PINGS) begin
         v = MAX_PINGS;
      end
      return CNT_W'(v);
   endfunction

endpackage

`default_nettype wire

// ----- design/urm_cell.sv -----
`default_nettype none

module urm_cell (
   input  wire logic                      clock,
   input  wire urm_pkg::urm_sort_ctl_type ctl,
   input  wire logic                      in_list,
   input  wire logic                      left_keep,
   input  wire logic [urm_pkg::DIST_W-1:0] left_value,
   output logic                           keep,
   output logic [urm_pkg::DIST_W-1:0]     value
);

   logic [urm_pkg::DIST_W-1:0] value_ff;
   logic [urm_pkg::DIST_W-1:0] value_in;

   // Hold when this entry is not smaller than the new one (equal entries stay ahead)
   assign keep  = in_list && (value_ff >= ctl.value);
   assign value = value_ff;

   // Hold, take the new entry, or take the left neighbour's entry
   always_comb begin
      value_in = value_ff;
      if (ctl.ins && !keep) begin
         if (left_keep) begin
            value_in = ctl.value;
         end else begin
            value_in = left_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ----- design/urm_sorter.sv -----
`default_nettype none

module urm_sorter (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire urm_pkg::urm_sort_ctl_type ctl,
   output logic [urm_pkg::CNT_W-1:0]      count,
   output logic [urm_pkg::DIST_W-1:0]     median
);

   logic [urm_pkg::CNT_W-1:0]  count_ff;
   logic [urm_pkg::CNT_W-1:0]  count_in;
   logic                       ins_ok;
   urm_pkg::urm_sort_ctl_type  cell_ctl;
   logic                       keep       [urm_pkg::MAX_PINGS];
   logic [urm_pkg::DIST_W-1:0] cell_value [urm_pkg::MAX_PINGS];

   // Drop an insertion once the row is full
   assign ins_ok = ctl.ins && (count_ff < urm_pkg::CNT_W'(urm_pkg::MAX_PINGS));

   always_comb begin
      cell_ctl     = ctl;
      cell_ctl.ins = ins_ok;
   end

   // Row of cells, descending from cell 0
   for (genvar gi = 0; gi < urm_pkg::MAX_PINGS; gi++) begin : g_cell
      if (gi == 0) begin : g_head
         urm_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .in_list    (count_ff > urm_pkg::CNT_W'(gi)),
            .left_keep  (1'b1),
            .left_value (ctl.value),
            .keep       (keep[gi]),
            .value      (cell_value[gi])
         );
      end else begin : g_body
         urm_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl),
            .in_list    (count_ff > urm_pkg::CNT_W'(gi)),
            .left_keep  (keep[gi-1]),
            .left_value (cell_value[gi-1]),
            .keep       (keep[gi]),
            .value      (cell_value[gi])
         );
      end
   end

   // Advance the fill count, clear it at the start of a run
   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ins_ok) begin
         count_in = count_ff + urm_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count  = count_ff;
   assign median = cell_value[urm_pkg::IDX_W'(count_ff >> 1)];

endmodule

`default_nettype wire

// ----- design/ultrasonic_ranger_median.sv -----
// Each accepted tick passes through accept, 16x16 multiply, round and range
// check, insertion into the cell row and result send; a new tick is taken
// only once the previous one is sent. A stalled result holds the next tick
// in its send stage and no further tick is accepted until it drains.
// Reset (synchronous) restores register defaults and idles the ranger; the
// sorted cells are not cleared and are only read after being written in a run.
`default_nettype none

module ultrasonic_ranger_median (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire urm_pkg::urm_req_type       req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output urm_pkg::urm_rsp_type            rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [urm_pkg::CSR_A_W-1:0] csr_index,
   input  wire logic [urm_pkg::CSR_D_W-1:0] csr_data
);

   typedef enum logic [1:0] {PH_IDLE, PH_PING, PH_WAIT} phase_type;
   typedef enum logic [2:0] {SQ_TAKE, SQ_MUL, SQ_CONV, SQ_INS, SQ_SEND} seq_type;

   localparam int TE_W   = urm_pkg::TICK_W + 2;
   localparam int PROD_W = 2 * urm_pkg::US_W;
   localparam int D_W    = PROD_W + 1 - 12;

   // Configuration registers
   logic [urm_pkg::US_W-1:0]   scale_ff, scale_in;
   logic [urm_pkg::US_W-1:0]   max_pulse_ff, max_pulse_in;
   logic [urm_pkg::DIST_W-1:0] min_dist_ff, min_dist_in;
   logic [urm_pkg::DIST_W-1:0] max_dist_ff, max_dist_in;
   logic [urm_pkg::US_W-1:0]   timeout_ff, timeout_in;
   logic [urm_pkg::TICK_W-1:0] period_ff, period_in;
   logic [urm_pkg::TRIG_W-1:0] trig_width_ff, trig_width_in;

   // Ranging state
   phase_type                  phase_ff, phase_in;
   seq_type                    seq_ff, seq_in;
   logic [urm_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [urm_pkg::US_W-1:0]   pulse_ff, pulse_in;
   logic                       echo_seen_ff, echo_seen_in;
   logic [urm_pkg::CNT_W-1:0]  attempts_ff, attempts_in;

   // Per-tick working registers
   logic                       trig_ff, trig_in;
   logic                       busy_ff, busy_in;
   logic                       pdone_ff, pdone_in;
   logic                       echo_end_ff, echo_end_in;
   logic                       mdone_ff, mdone_in;
   logic [urm_pkg::US_W-1:0]   width_ff, width_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic                       pecho_ff, pecho_in;
   logic [urm_pkg::DIST_W-1:0] pcm_ff, pcm_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   urm_pkg::urm_rsp_type       rsp_ff, rsp_in;

   // Tick decode
   logic                       take;
   logic                       begin_run, begin_ping;
   phase_type                  ph0;
   logic [urm_pkg::TICK_W-1:0] t0;
   logic [urm_pkg::US_W-1:0]   pw0;
   logic                       es0;
   logic [urm_pkg::CNT_W-1:0]  att0;
   logic [TE_W-1:0]            trig_end, echo_end_tick;
   logic                       in_lead, in_trig, timed_out;
   logic [D_W-1:0]             dist_q4;
   logic                       out_free;

   urm_pkg::urm_sort_ctl_type  sort_ctl;
   logic [urm_pkg::CNT_W-1:0]  sort_count;
   logic [urm_pkg::DIST_W-1:0] sort_median;

   assign take      = req_valid && req_ready;
   assign req_ready = (seq_ff == SQ_TAKE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Round to nearest Q4 centimetres
   assign dist_q4 = D_W'(({1'b0, prod_ff} + (PROD_W + 1)'(2048)) >> 12);

   // Ping timing boundaries
   assign trig_end      = TE_W'(trig_width_ff) + TE_W'(2);
   assign echo_end_tick = trig_end + TE_W'(timeout_ff);

   // Decode one tick: pacing, trigger, echo timing
   always_comb begin
      begin_run  = (phase_ff == PH_IDLE) && req_data.start_req;
      begin_ping = begin_run || ((phase_ff == PH_WAIT) && (tick_ff >= period_ff));
      ph0  = begin_ping ? PH_PING : phase_ff;
      t0   = begin_ping ? '0 : tick_ff;
      pw0  = begin_ping ? '0 : pulse_ff;
      es0  = begin_ping ? 1'b0 : echo_seen_ff;
      att0 = begin_run ? urm_pkg::clamp_pings(req_data.pings_requested) : attempts_ff;

      in_lead   = t0 < urm_pkg::TICK_W'(2);
      in_trig   = !in_lead && (TE_W'(t0) < trig_end);
      timed_out = TE_W'(t0) >= echo_end_tick;

      phase_in     = ph0;
      pulse_in     = pw0;
      echo_seen_in = es0;
      attempts_in  = att0;
      trig_in      = 1'b0;
      pdone_in     = 1'b0;
      echo_end_in  = 1'b0;
      mdone_in     = 1'b0;
      width_in     = (pw0 < max_pulse_ff) ? pw0 : max_pulse_ff;

      if (ph0 == PH_PING) begin
         if (in_lead) begin
            trig_in = 1'b0;
         end else if (in_trig) begin
            trig_in = 1'b1;
         end else if (timed_out) begin
            pdone_in = 1'b1;
         end else if (es0 && !req_data.echo_level) begin
            pdone_in    = 1'b1;
            echo_end_in = 1'b1;
         end else if (req_data.echo_level) begin
            echo_seen_in = 1'b1;
            if (!es0) begin
               pulse_in = urm_pkg::US_W'(1);
            end else if (pw0 != '1) begin
               pulse_in = pw0 + urm_pkg::US_W'(1);
            end
         end
         // Close the ping and either pace the next or finish the run
         if (pdone_in) begin
            echo_seen_in = 1'b0;
            pulse_in     = '0;
            if (att0 != '0) begin
               attempts_in = att0 - urm_pkg::CNT_W'(1);
            end
            if (attempts_in == '0) begin
               mdone_in = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_WAIT;
            end
         end
      end

      busy_in = (phase_in != PH_IDLE);
      tick_in = t0;
      if (busy_in && (t0 != '1)) begin
         tick_in = t0 + urm_pkg::TICK_W'(1);
      end
   end

   // Convert the finished echo and range-check it
   always_comb begin
      prod_in  = PROD_W'(width_ff) * PROD_W'(scale_ff);
      pecho_in = echo_end_ff && (dist_q4 <= D_W'(max_dist_ff));
      pcm_in   = '0;
      if (pecho_in) begin
         pcm_in = (dist_q4 < D_W'(min_dist_ff)) ? min_dist_ff : urm_pkg::DIST_W'(dist_q4);
      end
   end

   // Insertion into the cell row
   always_comb begin
      sort_ctl.clear = take && begin_run;
      sort_ctl.ins   = (seq_ff == SQ_INS) && pecho_ff;
      sort_ctl.value = pcm_ff;
   end

   urm_sorter u_sorter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (sort_ctl),
      .count  (sort_count),
      .median (sort_median)
   );

   // Sequence one tick through the working stages
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SQ_TAKE: if (take) seq_in = SQ_MUL;
         SQ_MUL:  seq_in = SQ_CONV;
         SQ_CONV: seq_in = SQ_INS;
         SQ_INS:  seq_in = SQ_SEND;
         SQ_SEND: if (out_free) seq_in = SQ_TAKE;
         default: seq_in = SQ_TAKE;
      endcase
   end

   // Form the result transaction
   always_comb begin
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      if ((seq_ff == SQ_SEND) && out_free) begin
         rsp_valid_in          = 1'b1;
         rsp_in.trigger_level  = trig_ff;
         rsp_in.busy_res       = busy_ff;
         rsp_in.ping_done      = pdone_ff;
         rsp_in.ping_echoed    = pecho_ff;
         rsp_in.ping_cm_q4     = pcm_ff;
         rsp_in.median_done    = mdone_ff;
         rsp_in.median_found   = mdone_ff && (sort_count != '0);
         rsp_in.median_cm_q4   = (mdone_ff && (sort_count != '0)) ? sort_median : '0;
         rsp_in.pings_used     = mdone_ff ? urm_pkg::REQ_W'(sort_count) : '0;
      end
   end

   // Register writes
   always_comb begin
      scale_in      = scale_ff;
      max_pulse_in  = max_pulse_ff;
      min_dist_in   = min_dist_ff;
      max_dist_in   = max_dist_ff;
      timeout_in    = timeout_ff;
      period_in     = period_ff;
      trig_width_in = trig_width_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            urm_pkg::CSR_SCALE:      scale_in      = csr_data[urm_pkg::US_W-1:0];
            urm_pkg::CSR_MAX_PULSE:  max_pulse_in  = csr_data[urm_pkg::US_W-1:0];
            urm_pkg::CSR_MIN_DIST:   min_dist_in   = csr_data[urm_pkg::DIST_W-1:0];
            urm_pkg::CSR_MAX_DIST:   max_dist_in   = csr_data[urm_pkg::DIST_W-1:0];
            urm_pkg::CSR_TIMEOUT:    timeout_in    = csr_data[urm_pkg::US_W-1:0];
            urm_pkg::CSR_PERIOD:     period_in     = csr_data[urm_pkg::TICK_W-1:0];
            urm_pkg::CSR_TRIG_WIDTH: trig_width_in = csr_data[urm_pkg::TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= urm_pkg::RST_SCALE;
         max_pulse_ff  <= urm_pkg::RST_MAX_PULSE;
         min_dist_ff   <= urm_pkg::RST_MIN_DIST;
         max_dist_ff   <= urm_pkg::RST_MAX_DIST;
         timeout_ff    <= urm_pkg::RST_TIMEOUT;
         period_ff     <= urm_pkg::RST_PERIOD;
         trig_width_ff <= urm_pkg::RST_TRIG_WIDTH;
         phase_ff      <= PH_IDLE;
         seq_ff        <= SQ_TAKE;
         tick_ff       <= '0;
         pulse_ff      <= '0;
         echo_seen_ff  <= 1'b0;
         attempts_ff   <= '0;
         trig_ff       <= 1'b0;
         busy_ff       <= 1'b0;
         pdone_ff      <= 1'b0;
         echo_end_ff   <= 1'b0;
         mdone_ff      <= 1'b0;
         width_ff      <= '0;
         prod_ff       <= '0;
         pecho_ff      <= 1'b0;
         pcm_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         scale_ff      <= scale_in;
         max_pulse_ff  <= max_pulse_in;
         min_dist_ff   <= min_dist_in;
         max_dist_ff   <= max_dist_in;
         timeout_ff    <= timeout_in;
         period_ff     <= period_in;
         trig_width_ff <= trig_width_in;
         seq_ff        <= seq_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_ff        <= rsp_in;
         // Advance the ranging state once per accepted tick
         if (take) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            pulse_ff     <= pulse_in;
            echo_seen_ff <= echo_seen_in;
            attempts_ff  <= attempts_in;
            trig_ff      <= trig_in;
            busy_ff      <= busy_in;
            pdone_ff     <= pdone_in;
            echo_end_ff  <= echo_end_in;
            mdone_ff     <= mdone_in;
            width_ff     <= width_in;
         end
         if (seq_ff == SQ_MUL) begin
            prod_ff <= prod_in;
         end
         if (seq_ff == SQ_CONV) begin
            pecho_ff <= pecho_in;
            pcm_ff   <= pcm_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_median_on_ping_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.median_done |-> rsp_ff.ping_done)
      else $error("median reported without a finished ping");

   a_found_has_pings: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.median_found |-> (rsp_ff.pings_used != '0))
      else $error("median found with no echoed ping");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      sort_count <= urm_pkg::CNT_W'(urm_pkg::MAX_PINGS))
      else $error("cell row fill count overflow");

   a_one_tick_at_a_time: assert property (@(posedge clock) disable iff (reset)
      take |=> !req_ready)
      else $error("tick taken while the previous one is in flight");

   a_echo_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ping_echoed |-> rsp_ff.ping_done)
      else $error("echo flagged on an unfinished ping");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {RANGER_IDLE, RANGER_PING, RANGER_WAIT} ranger_phase_type;
   typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_type;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   urm_pkg::urm_req_type          req_data  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   urm_pkg::urm_rsp_type          rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [urm_pkg::CSR_A_W-1:0]   csr_index = '0;
   logic [urm_pkg::CSR_D_W-1:0]   csr_data  = '0;

   // Register shadow, tracking every accepted write
   logic [urm_pkg::US_W-1:0]      cfg_scale      = urm_pkg::RST_SCALE;
   logic [urm_pkg::US_W-1:0]      cfg_max_pulse  = urm_pkg::RST_MAX_PULSE;
   logic [urm_pkg::DIST_W-1:0]    cfg_min_dist   = urm_pkg::RST_MIN_DIST;
   logic [urm_pkg::DIST_W-1:0]    cfg_max_dist   = urm_pkg::RST_MAX_DIST;
   logic [urm_pkg::US_W-1:0]      cfg_timeout    = urm_pkg::RST_TIMEOUT;
   logic [urm_pkg::TICK_W-1:0]    cfg_period     = urm_pkg::RST_PERIOD;
   logic [urm_pkg::TRIG_W-1:0]    cfg_trig_width = urm_pkg::RST_TRIG_WIDTH;

   // Ranger state as the predictor sees it
   ranger_phase_type              phase_q       = RANGER_IDLE;
   logic [urm_pkg::TICK_W-1:0]    ticks_q       = '0;
   logic [urm_pkg::US_W-1:0]      pulse_q       = '0;
   logic                          echo_high_q   = 1'b0;
   logic [urm_pkg::DIST_W-1:0]    ranked_cm [urm_pkg::MAX_PINGS] = '{default: '0};
   int unsigned                   ranked_count  = 0;
   int unsigned                   pings_left    = 0;

   urm_pkg::urm_req_type          tick_queue [$];
   urm_pkg::urm_rsp_type          predicted_outputs [$];
   logic                          tick_taken     = 1'b0;
   int unsigned                   send_gap_pct   = 0;
   int unsigned                   recv_stall_pct = 0;

   // Echo waveform generator
   logic                          echo_now = 1'b0;
   int unsigned                   echo_run = 0;

   int unsigned                   mismatch_count  = 0;
   int unsigned                   tick_total      = 0;
   int unsigned                   ping_total      = 0;
   int unsigned                   echo_total      = 0;
   int unsigned                   median_total    = 0;
   int unsigned                   found_total     = 0;
   int unsigned                   settings_total  = 0;

   ultrasonic_ranger_median u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic void begin_ping();
      phase_q     = RANGER_PING;
      ticks_q     = '0;
      pulse_q     = '0;
      echo_high_q = 1'b0;
   endfunction

   // Advance the ranger by one microsecond tick and return its outputs
   function automatic urm_pkg::urm_rsp_type next_ranger_outputs(
         input urm_pkg::urm_req_type tick);
      urm_pkg::urm_rsp_type res;
      int unsigned     count;
      int unsigned     elapsed;
      int unsigned     slot;
      longint unsigned width;
      longint unsigned dist_q4;
      res = '0;

      // Take a start only when idle; otherwise hold off until the period has run
      if (phase_q == RANGER_IDLE && tick.start_req) begin
         count = tick.pings_requested;
         if (count == 0) count = 1;
         if (count > urm_pkg::MAX_PINGS) count = urm_pkg::MAX_PINGS;
         pings_left   = count;
         ranked_count = 0;
         begin_ping();
      end else if (phase_q == RANGER_WAIT && ticks_q >= cfg_period) begin
         begin_ping();
      end

      if (phase_q == RANGER_PING) begin
         if (ticks_q < 2) begin
            res.trigger_level = 1'b0;
         end else if (ticks_q < 2 + cfg_trig_width) begin
            res.trigger_level = 1'b1;
         end else begin
            elapsed = ticks_q - 2 - cfg_trig_width;
            if (elapsed >= cfg_timeout) begin
               res.ping_done = 1'b1;
            end else if (echo_high_q && !tick.echo_level) begin
               // Falling echo: saturate, scale to Q4 with rounding, range check
               width   = (pulse_q < cfg_max_pulse) ? pulse_q : cfg_max_pulse;
               dist_q4 = (width * cfg_scale + 2048) >> 12;
               res.ping_done = 1'b1;
               if (dist_q4 <= cfg_max_dist) begin
                  if (dist_q4 < cfg_min_dist) dist_q4 = cfg_min_dist;
                  res.ping_echoed = 1'b1;
                  res.ping_cm_q4  = urm_pkg::DIST_W'(dist_q4);
               end
            end else if (tick.echo_level) begin
               if (!echo_high_q) begin
                  echo_high_q = 1'b1;
                  pulse_q     = 1;
               end else if (pulse_q != '1) begin
                  pulse_q = pulse_q + 1'b1;
               end
            end
         end

         if (res.ping_done) begin
            // Insert after any equal entries so the list stays descending
            if (res.ping_echoed && ranked_count < urm_pkg::MAX_PINGS) begin
               slot = ranked_count;
               while (slot > 0 && ranked_cm[slot-1] < res.ping_cm_q4) begin
                  ranked_cm[slot] = ranked_cm[slot-1];
                  slot--;
               end
               ranked_cm[slot] = res.ping_cm_q4;
               ranked_count++;
            end
            if (pings_left > 0) pings_left--;
            echo_high_q = 1'b0;
            pulse_q     = '0;
            if (pings_left == 0) begin
               res.median_done = 1'b1;
               res.pings_used  = urm_pkg::REQ_W'(ranked_count);
               if (ranked_count > 0) begin
                  res.median_found = 1'b1;
                  res.median_cm_q4 = ranked_cm[ranked_count >> 1];
               end
               phase_q = RANGER_IDLE;
            end else begin
               phase_q = RANGER_WAIT;
            end
         end
      end

      if (phase_q != RANGER_IDLE && ticks_q != '1) ticks_q = ticks_q + 1'b1;
      res.busy_res = (phase_q != RANGER_IDLE);
      return res;
   endfunction

   // Echo as on/off runs of random length, with start requests sprinkled in
   function automatic urm_pkg::urm_req_type random_tick();
      urm_pkg::urm_req_type tick;
      int unsigned pick;
      if (echo_run == 0) begin
         echo_now = !echo_now;
         if (echo_now) begin
            echo_run = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(10, 1);
         end else begin
            echo_run = $urandom_range(25, 1);
         end
      end
      echo_run--;
      tick.echo_level = echo_now;
      tick.start_req  = ($urandom_range(99) < 8);
      pick = $urandom_range(99);
      if (pick < 60) begin
         tick.pings_requested = urm_pkg::REQ_W'($urandom_range(3, 1));
      end else if (pick < 85) begin
         tick.pings_requested = urm_pkg::REQ_W'($urandom_range(16, 4));
      end else begin
         tick.pings_requested = urm_pkg::REQ_W'($urandom_range(31));
      end
      return tick;
   endfunction

   task automatic check_field(input string name, input logic [19:0] want,
                              input logic [19:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Drive tick transactions at the falling edge; hold each until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || tick_taken) begin
         if (tick_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_data  <= tick_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Sample both channels at the rising edge: check results, predict new ticks
   always @(posedge clock) begin
      if (reset) begin
         tick_taken <= 1'b0;
      end else begin
         tick_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("result transaction with no tick outstanding");
               mismatch_count++;
            end else begin
               automatic urm_pkg::urm_rsp_type want = predicted_outputs.pop_front();
               check_field("trigger_level", want.trigger_level, rsp_data.trigger_level);
               check_field("busy_res",      want.busy_res,      rsp_data.busy_res);
               check_field("ping_done",     want.ping_done,     rsp_data.ping_done);
               check_field("ping_echoed",   want.ping_echoed,   rsp_data.ping_echoed);
               check_field("ping_cm_q4",    want.ping_cm_q4,    rsp_data.ping_cm_q4);
               check_field("median_done",   want.median_done,   rsp_data.median_done);
               check_field("median_found",  want.median_found,  rsp_data.median_found);
               check_field("median_cm_q4",  want.median_cm_q4,  rsp_data.median_cm_q4);
               check_field("pings_used",    want.pings_used,    rsp_data.pings_used);
               tick_total++;
               ping_total   += want.ping_done;
               echo_total   += want.ping_echoed;
               median_total += want.median_done;
               found_total  += want.median_found;
            end
         end
         if (req_valid && req_ready) begin
            predicted_outputs.push_back(next_ranger_outputs(req_data));
         end
      end
   end

   task automatic write_reg(input logic [urm_pkg::CSR_A_W-1:0] idx,
                            input logic [urm_pkg::CSR_D_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         urm_pkg::CSR_SCALE:      cfg_scale      = val[urm_pkg::US_W-1:0];
         urm_pkg::CSR_MAX_PULSE:  cfg_max_pulse  = val[urm_pkg::US_W-1:0];
         urm_pkg::CSR_MIN_DIST:   cfg_min_dist   = val[urm_pkg::DIST_W-1:0];
         urm_pkg::CSR_MAX_DIST:   cfg_max_dist   = val[urm_pkg::DIST_W-1:0];
         urm_pkg::CSR_TIMEOUT:    cfg_timeout    = val[urm_pkg::US_W-1:0];
         urm_pkg::CSR_PERIOD:     cfg_period     = val[urm_pkg::TICK_W-1:0];
         urm_pkg::CSR_TRIG_WIDTH: cfg_trig_width = val[urm_pkg::TRIG_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input int unsigned scale, input int unsigned max_pulse,
                                input int unsigned min_dist, input int unsigned max_dist,
                                input int unsigned timeout, input int unsigned period,
                                input int unsigned trig_width);
      write_reg(urm_pkg::CSR_SCALE,      urm_pkg::CSR_D_W'(scale));
      write_reg(urm_pkg::CSR_MAX_PULSE,  urm_pkg::CSR_D_W'(max_pulse));
      write_reg(urm_pkg::CSR_MIN_DIST,   urm_pkg::CSR_D_W'(min_dist));
      write_reg(urm_pkg::CSR_MAX_DIST,   urm_pkg::CSR_D_W'(max_dist));
      write_reg(urm_pkg::CSR_TIMEOUT,    urm_pkg::CSR_D_W'(timeout));
      write_reg(urm_pkg::CSR_PERIOD,     urm_pkg::CSR_D_W'(period));
      write_reg(urm_pkg::CSR_TRIG_WIDTH, urm_pkg::CSR_D_W'(trig_width));
      settings_total++;
   endtask

   // Hold until every queued tick is taken and every result is back, then settle
   task automatic wait_until_drained();
      while (tick_queue.size() != 0 || req_valid || predicted_outputs.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic push_ticks(input int n, input logic start, input int unsigned req,
                             input logic echo);
      urm_pkg::urm_req_type tick;
      tick.start_req       = start;
      tick.pings_requested = urm_pkg::REQ_W'(req);
      tick.echo_level      = echo;
      repeat (n) tick_queue.push_back(tick);
   endtask

   task automatic run_phase(input int n, input pace_type pace, input bit hold_midway);
      case (pace)
         PACE_FULL:        begin send_gap_pct = 0;  recv_stall_pct = 0;  end
         PACE_SEND_GAPS:   begin send_gap_pct = 52; recv_stall_pct = 0;  end
         PACE_RECV_STALLS: begin send_gap_pct = 0;  recv_stall_pct = 52; end
         default:          begin send_gap_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int i = 0; i < n; i++) begin
         if (hold_midway && i == n / 2) wait_until_drained();
         tick_queue.push_back(random_tick());
      end
      wait_until_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed run of four pings: short echo raised to the minimum, start
      // while busy, echo high through the trigger, a timeout, equal distances
      apply_setting(65535, 3, 20, 40, 6, 0, 1);
      push_ticks(1, 1'b1, 4, 1'b1);
      push_ticks(1, 1'b1, 31, 1'b1);
      push_ticks(2, 1'b0, 0, 1'b1);
      push_ticks(1, 1'b0, 0, 1'b0);
      push_ticks(3, 1'b0, 0, 1'b0);
      push_ticks(2, 1'b0, 0, 1'b1);
      push_ticks(1, 1'b0, 0, 1'b0);
      push_ticks(10, 1'b0, 0, 1'b0);
      push_ticks(3, 1'b0, 0, 1'b0);
      push_ticks(2, 1'b0, 0, 1'b1);
      push_ticks(1, 1'b0, 0, 1'b0);
      push_ticks(1, 1'b0, 17, 1'b1);
      wait_until_drained();

      // Random echo traffic under a spread of register settings
      apply_setting(urm_pkg::RST_SCALE, urm_pkg::RST_MAX_PULSE, urm_pkg::RST_MIN_DIST,
                    urm_pkg::RST_MAX_DIST, urm_pkg::RST_TIMEOUT, urm_pkg::RST_PERIOD,
                    urm_pkg::RST_TRIG_WIDTH);
      run_phase(80, PACE_FULL, 1'b0);
      apply_setting(1126, 8, 0, 8000, 40, 30, 2);
      run_phase(90, PACE_SEND_GAPS, 1'b1);
      apply_setting(65535, 65535, 8000, 200, 30, 20, 1);
      run_phase(90, PACE_RECV_STALLS, 1'b0);
      apply_setting(0, 0, 100, 0, 25, 0, 0);
      run_phase(70, PACE_BOTH, 1'b0);
      apply_setting(20000, 12, 0, 50, 0, 5, 255);
      run_phase(140, PACE_FULL, 1'b0);
      apply_setting(4000, 10, 48, 300, 65535, 1048575, 1);
      run_phase(50, PACE_SEND_GAPS, 1'b0);
      apply_setting(30000, 30, 64, 1500, 35, 45, 3);
      run_phase(80, PACE_RECV_STALLS, 1'b0);
      apply_setting(9000, 20, 10, 600, 18, 12, 1);
      run_phase(80, PACE_BOTH, 1'b0);

      $display("Checked %0d ticks under %0d register settings: %0d pings (%0d echoed),",
               tick_total, settings_total, ping_total, echo_total);
      $display("and %0d median runs, %0d of them with a median found.",
               median_total, found_total);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- ultrasonic_ranger_median.f -----
design/urm_pkg.sv
design/urm_cell.sv
design/urm_sorter.sv
design/ultrasonic_ranger_median.sv
bench/tb.sv
